/* rtl/core/assert_macros.svh */
// Assertion helpers for the rank engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge out of reset.
`define PP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define PP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/pprk_pkg.sv */
// ----------------------------------------------------------------------------
// pprk_pkg
// Types, codes and constants of the integer push-style rank engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pprk_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;

  localparam int VTX_W   = 10;
  localparam int RANK_W  = 32;
  localparam int STAT_W  = 2;
  localparam int VC_W    = 11;
  localparam int IC_W    = 10;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [RANK_W-1:0] RANK_INIT = 32'd100000;
  localparam logic [RANK_W-1:0] RANK_BASE = 32'd15000;
  localparam logic [VC_W-1:0]   VC_RESET  = 11'd1024;
  localparam logic [IC_W-1:0]   IC_RESET  = 10'd10;

  // serial divider for rank / degree: dividend holds one rank
  localparam int DIV_W   = 32;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

  // floor(a / 3) = (a * RECIP3) >> 33 for any 32-bit a
  localparam logic [RANK_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT    = 1'd0,
    CFG_ITERATION_COUNT = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_READ_RD,
    ST_READ_DAT,
    ST_INIT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_DAT,
    ST_EDGE_DIV,
    ST_VTX_RD,
    ST_VTX_DAT,
    ST_VTX_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } in_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] status;
  } out_res_t;

endpackage

`default_nettype wire

/* rtl/core/pagerank_push_iteration_unit.sv */
// ----------------------------------------------------------------------------
// pagerank_push_iteration_unit
// Integer push-style rank engine: edge store, degree table, rank memories,
// a serial divider for the degree split and a reciprocal multiply for the
// damping step, all driven by a single sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                        | transfer
//  --------+------------------------------+-----------------------------
//  request | in_valid/in_ready/in_data    | valid/ready, one per command
//  result  | out_valid/out_ready/out_data | valid/ready, one per request
//  config  | cfg_we/cfg_index/cfg_wdata   | write on cfg_we, no wait
//
//  A clear request runs the degree sweep. In a run, each in-range edge costs
//  one 32-step pass through the serial divider; a stale edge skips it.
//  After reset a sweep of all MAX_VERTICES entries clears degrees and ranks;
//  no request is taken until it ends. A result waiting on out_ready holds the
//  sequencer in its final state; a new request is taken once it is back idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pagerank_push_iteration_unit #(
  parameter int MAX_VERTICES = pprk_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = pprk_pkg::MAX_EDGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pprk_pkg::in_req_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pprk_pkg::out_res_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pprk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pprk_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int UW  = (NW > pprk_pkg::VC_W) ? NW : pprk_pkg::VC_W;
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int EW1 = $clog2(MAX_EDGES + 1);
  localparam int DW  = EW1;
  localparam int DVW = (DW > 3) ? DW : 3;
  localparam int RW  = pprk_pkg::RANK_W;
  localparam int XW  = pprk_pkg::VTX_W;

  // memories
  logic [2*XW-1:0] edge_mem [MAX_EDGES];
  logic [DW-1:0]   deg_mem  [MAX_VERTICES];
  logic [RW-1:0]   cur_mem  [MAX_VERTICES];
  logic [RW-1:0]   next_mem [MAX_VERTICES];

  logic [2*XW-1:0] edge_rdata_r;
  logic [DW-1:0]   deg_rdata_r;
  logic [RW-1:0]   cur_rdata_r;
  logic [RW-1:0]   next_rdata_r;

  logic            edge_we;
  logic [EW-1:0]   edge_waddr, edge_raddr;
  logic [2*XW-1:0] edge_wdata;
  logic            deg_we;
  logic [VW-1:0]   deg_waddr, deg_raddr;
  logic [DW-1:0]   deg_wdata;
  logic            cur_we;
  logic [VW-1:0]   cur_waddr, cur_raddr;
  logic [RW-1:0]   cur_wdata;
  logic            next_we;
  logic [VW-1:0]   next_waddr, next_raddr;
  logic [RW-1:0]   next_wdata;

  // control state
  pprk_pkg::state_t  state_r, state_nxt;
  pprk_pkg::in_req_t req_r;
  pprk_pkg::out_res_t res_r, out_data_r;
  logic              out_valid_r;
  logic              clr_ranks_r;
  logic [pprk_pkg::VC_W-1:0] vc_r;
  logic [pprk_pkg::IC_W-1:0] ic_r, it_r;
  logic [EW1-1:0]    edge_total_r, e_r;
  logic [NW-1:0]     v_r;
  logic [XW-1:0]     dst_r;
  logic [RW-1:0]     acc_r;

  // serial divider
  logic [pprk_pkg::DIV_W-1:0]     div_q_r;
  logic [DVW-1:0]                 div_rem_r, div_den_r;
  logic [pprk_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [DVW:0]                   rem_sh, rem_sub;
  logic                           div_ge, div_done;

  // damping step: 15000 + n - ceil(n/6), ceil(n/6) = floor(((n+5)>>1)/3)
  logic [RW-1:0]   half_r;
  logic [RW-2:0]   q6_r;
  logic [RW:0]     next_plus;
  logic [2*RW-1:0] q6_prod;
  logic [RW-1:0]   vtx_rank;
  logic            vtx_step;

  logic [UW-1:0] n_used, vc_ext, max_ext;
  logic          src_ok, dst_ok, full;
  logic [XW-1:0] e_src, e_dst;
  logic          e_ok, sweep_end, vtx_end, edge_end, last_it;
  logic [RW:0]   sum_ext;
  logic [RW-1:0] sum_sat;

  always_comb begin
    vc_ext  = UW'(vc_r);
    max_ext = UW'(MAX_VERTICES);
    if (vc_r == '0) begin
      n_used = UW'(1);
    end else if (vc_ext > max_ext) begin
      n_used = max_ext;
    end else begin
      n_used = vc_ext;
    end
  end

  assign src_ok    = UW'(req_r.src_vertex) < n_used;
  assign dst_ok    = UW'(req_r.dst_vertex) < n_used;
  assign full      = edge_total_r == EW1'(MAX_EDGES);
  assign e_src     = edge_rdata_r[2*XW-1:XW];
  assign e_dst     = edge_rdata_r[XW-1:0];
  assign e_ok      = (UW'(e_src) < n_used) && (UW'(e_dst) < n_used);
  assign sweep_end = v_r == NW'(MAX_VERTICES - 1);
  assign vtx_end   = UW'(v_r) == n_used;
  assign edge_end  = e_r == edge_total_r;
  assign last_it   = (it_r + 1'b1) == ic_r;

  assign rem_sh   = {div_rem_r, div_q_r[pprk_pkg::DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_den_r};
  assign div_ge   = rem_sh >= {1'b0, div_den_r};
  assign div_done = div_cnt_r == pprk_pkg::DIV_STEPS;

  assign sum_ext   = {1'b0, acc_r} + {1'b0, div_q_r[RW-1:0]};
  assign sum_sat   = sum_ext[RW] ? '1 : sum_ext[RW-1:0];

  assign next_plus = {1'b0, next_rdata_r} + (RW+1)'(5);
  assign q6_prod   = half_r * pprk_pkg::RECIP3;
  assign vtx_rank  = pprk_pkg::RANK_BASE + (acc_r - RW'(q6_r));
  assign vtx_step  = div_cnt_r[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pprk_pkg::ST_CLEAR:    if (sweep_end) state_nxt = clr_ranks_r ? pprk_pkg::ST_IDLE
                                                                     : pprk_pkg::ST_DONE;
      pprk_pkg::ST_IDLE:     if (in_valid) state_nxt = pprk_pkg::ST_DISPATCH;
      pprk_pkg::ST_DISPATCH: begin
        case (req_r.mode)
          pprk_pkg::MODE_LOAD: begin
            if (!src_ok || !dst_ok || full) state_nxt = pprk_pkg::ST_DONE;
            else state_nxt = pprk_pkg::ST_LOAD_RD;
          end
          pprk_pkg::MODE_RUN:  state_nxt = pprk_pkg::ST_INIT;
          pprk_pkg::MODE_READ: state_nxt = dst_ok ? pprk_pkg::ST_READ_RD : pprk_pkg::ST_DONE;
          default:             state_nxt = pprk_pkg::ST_CLEAR;
        endcase
      end
      pprk_pkg::ST_LOAD_RD:  state_nxt = pprk_pkg::ST_LOAD_WR;
      pprk_pkg::ST_LOAD_WR:  state_nxt = pprk_pkg::ST_DONE;
      pprk_pkg::ST_READ_RD:  state_nxt = pprk_pkg::ST_READ_DAT;
      pprk_pkg::ST_READ_DAT: state_nxt = pprk_pkg::ST_DONE;
      pprk_pkg::ST_INIT: begin
        if (sweep_end) state_nxt = (ic_r == '0) ? pprk_pkg::ST_DONE : pprk_pkg::ST_EDGE_RD;
      end
      pprk_pkg::ST_EDGE_RD:  state_nxt = edge_end ? pprk_pkg::ST_VTX_RD : pprk_pkg::ST_EDGE_CHK;
      pprk_pkg::ST_EDGE_CHK: state_nxt = e_ok ? pprk_pkg::ST_EDGE_DAT : pprk_pkg::ST_EDGE_RD;
      pprk_pkg::ST_EDGE_DAT: begin
        state_nxt = (deg_rdata_r == '0) ? pprk_pkg::ST_EDGE_RD : pprk_pkg::ST_EDGE_DIV;
      end
      pprk_pkg::ST_EDGE_DIV: if (div_done) state_nxt = pprk_pkg::ST_EDGE_RD;
      pprk_pkg::ST_VTX_RD: begin
        if (vtx_end) state_nxt = last_it ? pprk_pkg::ST_DONE : pprk_pkg::ST_EDGE_RD;
        else state_nxt = pprk_pkg::ST_VTX_DAT;
      end
      pprk_pkg::ST_VTX_DAT:  state_nxt = pprk_pkg::ST_VTX_DIV;
      pprk_pkg::ST_VTX_DIV:  if (vtx_step) state_nxt = pprk_pkg::ST_VTX_RD;
      pprk_pkg::ST_DONE:     if (!out_valid_r || out_ready) state_nxt = pprk_pkg::ST_IDLE;
      default:               state_nxt = pprk_pkg::ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    in_ready   = state_r == pprk_pkg::ST_IDLE;
    edge_we    = 1'b0;
    edge_waddr = edge_total_r[EW-1:0];
    edge_wdata = {req_r.src_vertex, req_r.dst_vertex};
    edge_raddr = e_r[EW-1:0];
    deg_we     = 1'b0;
    deg_waddr  = VW'(req_r.src_vertex);
    deg_wdata  = deg_rdata_r + 1'b1;
    deg_raddr  = VW'(req_r.src_vertex);
    cur_we     = 1'b0;
    cur_waddr  = v_r[VW-1:0];
    cur_wdata  = pprk_pkg::RANK_INIT;
    cur_raddr  = VW'(req_r.dst_vertex);
    next_we    = 1'b0;
    next_waddr = v_r[VW-1:0];
    next_wdata = '0;
    next_raddr = v_r[VW-1:0];
    case (state_r)
      pprk_pkg::ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = v_r[VW-1:0];
        deg_wdata = '0;
        cur_we    = clr_ranks_r;
        next_we   = clr_ranks_r;
      end
      pprk_pkg::ST_LOAD_WR: begin
        edge_we = 1'b1;
        deg_we  = 1'b1;
      end
      pprk_pkg::ST_INIT: begin
        cur_we  = 1'b1;
        next_we = 1'b1;
      end
      pprk_pkg::ST_EDGE_CHK: begin
        deg_raddr  = VW'(e_src);
        cur_raddr  = VW'(e_src);
        next_raddr = VW'(e_dst);
      end
      pprk_pkg::ST_EDGE_DIV: begin
        next_we    = div_done;
        next_waddr = VW'(dst_r);
        next_wdata = sum_sat;
      end
      pprk_pkg::ST_VTX_DIV: begin
        cur_we    = vtx_step;
        cur_wdata = vtx_rank;
        next_we   = vtx_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_rdata_r <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rdata_r <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rdata_r <= next_mem[next_raddr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pprk_pkg::ST_CLEAR;
      clr_ranks_r  <= 1'b1;
      out_valid_r  <= 1'b0;
      vc_r         <= pprk_pkg::VC_RESET;
      ic_r         <= pprk_pkg::IC_RESET;
      edge_total_r <= '0;
      v_r          <= '0;
      e_r          <= '0;
      it_r         <= '0;
      div_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == pprk_pkg::CFG_VERTEX_COUNT) vc_r <= cfg_wdata[pprk_pkg::VC_W-1:0];
        else ic_r <= cfg_wdata[pprk_pkg::IC_W-1:0];
      end
      if (state_r == pprk_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        pprk_pkg::ST_CLEAR: v_r <= sweep_end ? '0 : v_r + 1'b1;
        pprk_pkg::ST_IDLE: begin
          req_r <= in_data;
          res_r <= '{rank: '0, status: pprk_pkg::STAT_OK};
        end
        pprk_pkg::ST_DISPATCH: begin
          v_r <= '0;
          if (req_r.mode == pprk_pkg::MODE_LOAD) begin
            if (!src_ok || !dst_ok) res_r.status <= pprk_pkg::STAT_BAD;
            else if (full) res_r.status <= pprk_pkg::STAT_FULL;
          end
          if (req_r.mode == pprk_pkg::MODE_READ && !dst_ok) res_r.status <= pprk_pkg::STAT_BAD;
          if (req_r.mode == pprk_pkg::MODE_CLEAR) begin
            clr_ranks_r  <= 1'b0;
            edge_total_r <= '0;
          end
        end
        pprk_pkg::ST_LOAD_WR: edge_total_r <= edge_total_r + 1'b1;
        pprk_pkg::ST_READ_DAT: res_r.rank <= cur_rdata_r;
        pprk_pkg::ST_INIT: begin
          v_r  <= sweep_end ? '0 : v_r + 1'b1;
          e_r  <= '0;
          it_r <= '0;
        end
        pprk_pkg::ST_EDGE_RD: v_r <= '0;
        pprk_pkg::ST_EDGE_CHK: begin
          dst_r <= e_dst;
          if (!e_ok) e_r <= e_r + 1'b1;
        end
        pprk_pkg::ST_EDGE_DAT: begin
          acc_r     <= next_rdata_r;
          div_q_r   <= pprk_pkg::DIV_W'(cur_rdata_r);
          div_rem_r <= '0;
          div_den_r <= DVW'(deg_rdata_r);
          div_cnt_r <= '0;
          if (deg_rdata_r == '0) e_r <= e_r + 1'b1;
        end
        pprk_pkg::ST_EDGE_DIV: begin
          if (div_done) begin
            e_r <= e_r + 1'b1;
          end else begin
            div_rem_r <= div_ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
            div_q_r   <= {div_q_r[pprk_pkg::DIV_W-2:0], div_ge};
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        pprk_pkg::ST_VTX_RD: begin
          if (vtx_end) begin
            it_r <= it_r + 1'b1;
            e_r  <= '0;
          end
        end
        pprk_pkg::ST_VTX_DAT: begin
          acc_r     <= next_rdata_r;
          half_r    <= next_plus[RW:1];
          div_cnt_r <= '0;
        end
        // first the quotient is taken, then the new rank is written
        pprk_pkg::ST_VTX_DIV: begin
          if (vtx_step) begin
            v_r <= v_r + 1'b1;
          end else begin
            q6_r      <= q6_prod[2*RW-1:RW+1];
            div_cnt_r <= pprk_pkg::DIV_CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "assert_macros.svh"

  `PP_ASSERT(a_edge_bound, edge_total_r <= EW1'(MAX_EDGES), "edge count beyond store depth")
  `PP_ASSERT(a_div_bound, div_cnt_r <= pprk_pkg::DIV_STEPS, "divider step count overrun")
  `PP_ASSERT_IMP(a_one_req, in_valid && in_ready, ##1 !in_ready, "request taken while busy")
  `PP_ASSERT_IMP(a_err_zero, out_valid && out_data.status != pprk_pkg::STAT_OK,
                 out_data.rank == '0, "error result carries a rank")

endmodule

`default_nettype wire
